// File: design/slex_pkg.sv
`timescale 1ns / 1ps
package slex_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int LENGTH_BITS_DEF   = 16;
   localparam int KEYWORD_CHARS_DEF = 6;
   localparam int LINE_BITS         = 32;
   localparam int KIND_BITS         = 6;
   localparam int NUM_KEYWORDS      = 9;
   localparam int NUM_CAND          = 4;
   localparam int MAX_PUSH          = 3;
   localparam int QUEUE_DEPTH       = 8;

   localparam logic [KIND_BITS-1:0] K_LPAREN      = 6'd0;
   localparam logic [KIND_BITS-1:0] K_RPAREN      = 6'd1;
   localparam logic [KIND_BITS-1:0] K_LBRACE      = 6'd2;
   localparam logic [KIND_BITS-1:0] K_RBRACE      = 6'd3;
   localparam logic [KIND_BITS-1:0] K_LBRACK      = 6'd4;
   localparam logic [KIND_BITS-1:0] K_RBRACK      = 6'd5;
   localparam logic [KIND_BITS-1:0] K_COMMA       = 6'd6;
   localparam logic [KIND_BITS-1:0] K_COLON       = 6'd7;
   localparam logic [KIND_BITS-1:0] K_COLON_COLON = 6'd8;
   localparam logic [KIND_BITS-1:0] K_DOT         = 6'd9;
   localparam logic [KIND_BITS-1:0] K_MINUS       = 6'd10;
   localparam logic [KIND_BITS-1:0] K_THIN_ARROW  = 6'd11;
   localparam logic [KIND_BITS-1:0] K_PLUS        = 6'd12;
   localparam logic [KIND_BITS-1:0] K_SLASH       = 6'd13;
   localparam logic [KIND_BITS-1:0] K_STAR        = 6'd14;
   localparam logic [KIND_BITS-1:0] K_AND         = 6'd15;
   localparam logic [KIND_BITS-1:0] K_NOT         = 6'd16;
   localparam logic [KIND_BITS-1:0] K_NEQ         = 6'd17;
   localparam logic [KIND_BITS-1:0] K_EQ          = 6'd18;
   localparam logic [KIND_BITS-1:0] K_EQ_EQ       = 6'd19;
   localparam logic [KIND_BITS-1:0] K_ARROW       = 6'd20;
   localparam logic [KIND_BITS-1:0] K_LT          = 6'd21;
   localparam logic [KIND_BITS-1:0] K_LTE         = 6'd22;
   localparam logic [KIND_BITS-1:0] K_GT          = 6'd23;
   localparam logic [KIND_BITS-1:0] K_GTE         = 6'd24;
   localparam logic [KIND_BITS-1:0] K_OR          = 6'd25;
   localparam logic [KIND_BITS-1:0] K_PIPE        = 6'd26;
   localparam logic [KIND_BITS-1:0] K_KW_BASE     = 6'd27;
   localparam logic [KIND_BITS-1:0] K_STR         = 6'd36;
   localparam logic [KIND_BITS-1:0] K_NUM         = 6'd37;
   localparam logic [KIND_BITS-1:0] K_IDENT       = 6'd38;
   localparam logic [KIND_BITS-1:0] K_END         = 6'd39;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_OP, MODE_INT, MODE_DOT, MODE_FRAC, MODE_IDENT, MODE_STR
   } scan_mode_type;

   typedef struct packed {
      logic                 hit;
      logic [KIND_BITS-1:0] kind;
   } kind_hit_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return c == "_" || is_alpha(c) || is_digit(c);
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return c == ":" || c == "-" || c == "&" || c == "!" || c == "=" ||
             c == "<" || c == ">" || c == "|";
   endfunction

   function automatic kind_hit_type single_kind(input logic [7:0] c);
      kind_hit_type r;
      r = '{hit: 1'b1, kind: K_LPAREN};
      case (c)
         "(": r.kind = K_LPAREN;
         ")": r.kind = K_RPAREN;
         "{": r.kind = K_LBRACE;
         "}": r.kind = K_RBRACE;
         "[": r.kind = K_LBRACK;
         "]": r.kind = K_RBRACK;
         ",": r.kind = K_COMMA;
         ".": r.kind = K_DOT;
         "+": r.kind = K_PLUS;
         "/": r.kind = K_SLASH;
         "*": r.kind = K_STAR;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic kind_hit_type op_pair(input logic [7:0] a, input logic [7:0] b);
      kind_hit_type r;
      r = '{hit: 1'b1, kind: K_COLON_COLON};
      if (a == ":" && b == ":") r.kind = K_COLON_COLON;
      else if (a == "-" && b == ">") r.kind = K_THIN_ARROW;
      else if (a == "&" && b == "&") r.kind = K_AND;
      else if (a == "!" && b == "=") r.kind = K_NEQ;
      else if (a == "=" && b == "=") r.kind = K_EQ_EQ;
      else if (a == "=" && b == ">") r.kind = K_ARROW;
      else if (a == "<" && b == "=") r.kind = K_LTE;
      else if (a == ">" && b == "=") r.kind = K_GTE;
      else if (a == "|" && b == "|") r.kind = K_OR;
      else r.hit = 1'b0;
      return r;
   endfunction

   // a lone ampersand has no single-character token
   function automatic kind_hit_type op_single(input logic [7:0] a);
      kind_hit_type r;
      r = '{hit: 1'b1, kind: K_COLON};
      case (a)
         ":": r.kind = K_COLON;
         "-": r.kind = K_MINUS;
         "!": r.kind = K_NOT;
         "=": r.kind = K_EQ;
         "<": r.kind = K_LT;
         ">": r.kind = K_GT;
         "|": r.kind = K_PIPE;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   // text reversed so the first character sits in the lowest byte
   function automatic logic [63:0] kw_text(input int k);
      logic [63:0] r;
      case (k)
         0: r = 64'("rav");
         1: r = 64'("lav");
         2: r = 64'("nf");
         3: r = 64'("_");
         4: r = 64'("epyt");
         5: r = 64'("nruter");
         6: r = 64'("hctam");
         7: r = 64'("eurt");
         default: r = 64'("eslaf");
      endcase
      return r;
   endfunction

   function automatic logic [3:0] kw_len(input int k);
      logic [3:0] r;
      case (k)
         0, 1: r = 4'd3;
         2: r = 4'd2;
         3: r = 4'd1;
         4, 7: r = 4'd4;
         5: r = 4'd6;
         default: r = 4'd5;
      endcase
      return r;
   endfunction

endpackage

// File: design/slex_scan.sv
`timescale 1ns / 1ps
module slex_scan
   import slex_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     step_end,
   input  logic [7:0]               step_char,
   output logic [NUM_CAND-1:0]      cand_valid,
   output logic [KIND_BITS-1:0]     cand_kind   [NUM_CAND],
   output logic [POSITION_BITS-1:0] cand_start  [NUM_CAND],
   output logic [LENGTH_BITS-1:0]   cand_len    [NUM_CAND],
   output logic [NUM_CAND-1:0]      cand_unterm,
   output logic [LINE_BITS-1:0]     cand_line
);

   localparam int KB = 8 * KEYWORD_CHARS;

   scan_mode_type            mode_ff, mode_in;
   logic [7:0]               pend_ff, pend_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] lstart_ff, lstart_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [KB-1:0]            kwbuf_ff, kwbuf_in;
   logic [LENGTH_BITS-1:0]   llen_ff, llen_in;

   logic [LENGTH_BITS:0]     sum1, sum2;
   logic [LENGTH_BITS-1:0]   llen_p1, llen_p2;
   logic [KIND_BITS-1:0]     ident_kind;
   logic [63:0]              kw_full;
   logic [KB-1:0]            kw_pack;
   logic                     eaten;
   kind_hit_type             pair, one_op, punct;

   assign sum1    = {1'b0, llen_ff} + (LENGTH_BITS + 1)'(1);
   assign sum2    = {1'b0, llen_ff} + (LENGTH_BITS + 1)'(2);
   assign llen_p1 = sum1[LENGTH_BITS] ? '1 : sum1[LENGTH_BITS-1:0];
   assign llen_p2 = sum2[LENGTH_BITS] ? '1 : sum2[LENGTH_BITS-1:0];
   assign cand_line = line_ff;

   // all nine keywords compared in parallel
   always_comb begin
      ident_kind = K_IDENT;
      kw_full = '0;
      kw_pack = '0;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         kw_full = kw_text(k);
         for (int i = 0; i < KEYWORD_CHARS; i++) begin
            kw_pack[8*i +: 8] = kw_full[8*i +: 8];
         end
         if (llen_ff == LENGTH_BITS'(kw_len(k)) && kwbuf_ff == kw_pack) begin
            ident_kind = K_KW_BASE + KIND_BITS'(k);
         end
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      lstart_in = lstart_ff;
      line_in   = line_ff;
      kwbuf_in  = kwbuf_ff;
      llen_in   = llen_ff;
      eaten     = 1'b0;
      cand_valid  = '0;
      cand_unterm = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         cand_kind[i]  = K_END;
         cand_start[i] = lstart_ff;
         cand_len[i]   = llen_ff;
      end
      pair   = op_pair(pend_ff, step_char);
      one_op = op_single(pend_ff);
      punct  = single_kind(step_char);

      // slot 0 and 1: token closed by this byte, slot 2: new one-byte token, slot 3: end
      if (step_en && step_end) begin
         unique case (mode_ff)
            MODE_OP: begin
               cand_valid[0] = one_op.hit;
               cand_kind[0]  = one_op.kind;
               cand_len[0]   = LENGTH_BITS'(1);
            end
            MODE_INT, MODE_FRAC: begin
               cand_valid[0] = 1'b1;
               cand_kind[0]  = K_NUM;
            end
            MODE_DOT: begin
               cand_valid[0] = 1'b1;
               cand_kind[0]  = K_NUM;
               cand_valid[1] = 1'b1;
               cand_kind[1]  = K_DOT;
               cand_start[1] = pos_ff - POSITION_BITS'(1);
               cand_len[1]   = LENGTH_BITS'(1);
            end
            MODE_IDENT: begin
               cand_valid[0] = 1'b1;
               cand_kind[0]  = ident_kind;
            end
            MODE_STR: begin
               cand_valid[0]  = 1'b1;
               cand_kind[0]   = K_STR;
               cand_unterm[0] = 1'b1;
            end
            default: ;
         endcase
         cand_valid[3] = 1'b1;
         cand_kind[3]  = K_END;
         cand_start[3] = pos_ff;
         cand_len[3]   = '0;
         mode_in   = MODE_IDLE;
         pend_in   = '0;
         pos_in    = '0;
         lstart_in = '0;
         line_in   = LINE_BITS'(1);
         kwbuf_in  = '0;
         llen_in   = '0;
      end else if (step_en) begin
         pos_in = pos_ff + POSITION_BITS'(1);
         unique case (mode_ff)
            MODE_OP: begin
               mode_in = MODE_IDLE;
               if (pair.hit) begin
                  cand_valid[0] = 1'b1;
                  cand_kind[0]  = pair.kind;
                  cand_len[0]   = LENGTH_BITS'(2);
                  eaten = 1'b1;
               end else begin
                  cand_valid[0] = one_op.hit;
                  cand_kind[0]  = one_op.kind;
                  cand_len[0]   = LENGTH_BITS'(1);
               end
            end
            MODE_INT: begin
               if (is_digit(step_char)) begin
                  llen_in = llen_p1;
                  eaten = 1'b1;
               end else if (step_char == ".") begin
                  mode_in = MODE_DOT;
                  eaten = 1'b1;
               end else begin
                  cand_valid[0] = 1'b1;
                  cand_kind[0]  = K_NUM;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DOT: begin
               if (is_digit(step_char)) begin
                  llen_in = llen_p2;
                  mode_in = MODE_FRAC;
                  eaten = 1'b1;
               end else begin
                  cand_valid[0] = 1'b1;
                  cand_kind[0]  = K_NUM;
                  cand_valid[1] = 1'b1;
                  cand_kind[1]  = K_DOT;
                  cand_start[1] = pos_ff - POSITION_BITS'(1);
                  cand_len[1]   = LENGTH_BITS'(1);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_FRAC: begin
               if (is_digit(step_char)) begin
                  llen_in = llen_p1;
                  eaten = 1'b1;
               end else begin
                  cand_valid[0] = 1'b1;
                  cand_kind[0]  = K_NUM;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_word(step_char)) begin
                  for (int i = 0; i < KEYWORD_CHARS; i++) begin
                     if (llen_ff == LENGTH_BITS'(i)) kwbuf_in[8*i +: 8] = step_char;
                  end
                  llen_in = llen_p1;
                  eaten = 1'b1;
               end else begin
                  cand_valid[0] = 1'b1;
                  cand_kind[0]  = ident_kind;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STR: begin
               llen_in = llen_p1;
               eaten = 1'b1;
               if (step_char == "\"") begin
                  cand_valid[0] = 1'b1;
                  cand_kind[0]  = K_STR;
                  cand_len[0]   = llen_p1;
                  mode_in = MODE_IDLE;
               end else if (step_char == "\n") begin
                  line_in = line_ff + LINE_BITS'(1);
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         if (!eaten) begin
            if (punct.hit) begin
               cand_valid[2] = 1'b1;
               cand_kind[2]  = punct.kind;
               cand_start[2] = pos_ff;
               cand_len[2]   = LENGTH_BITS'(1);
            end else if (is_op_start(step_char)) begin
               mode_in = MODE_OP;
               pend_in = step_char;
            end else if (step_char == "\n") begin
               line_in = line_ff + LINE_BITS'(1);
            end else if (step_char == "\"") begin
               mode_in = MODE_STR;
            end else if (is_digit(step_char)) begin
               mode_in = MODE_INT;
            end else if (is_word(step_char)) begin
               mode_in  = MODE_IDENT;
               kwbuf_in = KB'(step_char);
            end
            if (!punct.hit && (is_op_start(step_char) || step_char == "\"" ||
                               is_word(step_char))) begin
               lstart_in = pos_ff;
               llen_in   = LENGTH_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         pos_ff    <= '0;
         lstart_ff <= '0;
         line_ff   <= LINE_BITS'(1);
         kwbuf_ff  <= '0;
         llen_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         pos_ff    <= pos_in;
         lstart_ff <= lstart_in;
         line_ff   <= line_in;
         kwbuf_ff  <= kwbuf_in;
         llen_ff   <= llen_in;
      end
   end

endmodule

// File: design/slex_queue.sv
`timescale 1ns / 1ps
module slex_queue
   import slex_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_en,
   input  logic [NUM_CAND-1:0]      cand_valid,
   input  logic [KIND_BITS-1:0]     cand_kind   [NUM_CAND],
   input  logic [POSITION_BITS-1:0] cand_start  [NUM_CAND],
   input  logic [LENGTH_BITS-1:0]   cand_len    [NUM_CAND],
   input  logic [NUM_CAND-1:0]      cand_unterm,
   input  logic [LINE_BITS-1:0]     cand_line,
   output logic                     room,
   output logic                     head_valid,
   input  logic                     head_pop,
   output logic [KIND_BITS-1:0]     head_kind,
   output logic [POSITION_BITS-1:0] head_start,
   output logic [LENGTH_BITS-1:0]   head_len,
   output logic [LINE_BITS-1:0]     head_line,
   output logic                     head_unterm,
   output logic                     head_last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [KIND_BITS-1:0]     kind_q   [QUEUE_DEPTH];
   logic [POSITION_BITS-1:0] start_q  [QUEUE_DEPTH];
   logic [LENGTH_BITS-1:0]   len_q    [QUEUE_DEPTH];
   logic [LINE_BITS-1:0]     line_q   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   unterm_q, last_q;

   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] off [NUM_CAND];
   logic [NUM_CAND-1:0] is_last;
   logic [CNT_W-1:0] push_n;

   // candidates are packed down to consecutive slots; the last one carries tlast
   always_comb begin
      push_n = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         off[i] = push_n[PTR_W-1:0];
         push_n = push_n + CNT_W'(cand_valid[i]);
         is_last[i] = cand_valid[i];
         for (int j = i + 1; j < NUM_CAND; j++) begin
            if (cand_valid[j]) is_last[i] = 1'b0;
         end
      end
      if (!push_en) push_n = '0;
   end

   assign room       = count_ff <= CNT_W'(QUEUE_DEPTH - MAX_PUSH);
   assign head_valid = count_ff != '0;
   assign head_kind  = kind_q[rptr_ff];
   assign head_start = start_q[rptr_ff];
   assign head_len   = len_q[rptr_ff];
   assign head_line  = line_q[rptr_ff];
   assign head_unterm = unterm_q[rptr_ff];
   assign head_last  = last_q[rptr_ff];

   assign wptr_in  = wptr_ff + push_n[PTR_W-1:0];
   assign rptr_in  = rptr_ff + PTR_W'(head_pop);
   assign count_in = count_ff + push_n - CNT_W'(head_pop);

   always_ff @(posedge clock) begin
      if (push_en) begin
         for (int i = 0; i < NUM_CAND; i++) begin
            if (cand_valid[i]) begin
               kind_q[wptr_ff + off[i]]   <= cand_kind[i];
               start_q[wptr_ff + off[i]]  <= cand_start[i];
               len_q[wptr_ff + off[i]]    <= cand_len[i];
               line_q[wptr_ff + off[i]]   <= cand_line;
               unterm_q[wptr_ff + off[i]] <= cand_unterm[i];
               last_q[wptr_ff + off[i]]   <= is_last[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: design/source_lexer_core.sv
`timescale 1ns / 1ps
// Streaming source scanner: one source byte (or the end marker) is taken per clock
// cycle and turned into tokens of kind, start offset, length and line. The scan
// state updates in the cycle of the transfer and the finished tokens, up to three
// per transfer, go into an eight-entry token queue that feeds the result side one
// token per cycle; req_tready is low only while that queue has fewer than three free
// entries, so with the result side ready the sustained rate is one byte per cycle
// and a token that meets an empty queue shows in the cycle after its closing byte.
module source_lexer_core
   import slex_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
   localparam int RSP_DATA_W   = ((POSITION_BITS + LENGTH_BITS + LINE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // char_byte
   input  logic [0:0]            req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // token_start, token_length, line_number
   output logic [6:0]            rsp_tuser,   // token_kind, unterminated
   output logic                  rsp_tlast    // last_of_run
);

   logic                     step_en;
   logic [NUM_CAND-1:0]      cand_valid, cand_unterm;
   logic [KIND_BITS-1:0]     cand_kind  [NUM_CAND];
   logic [POSITION_BITS-1:0] cand_start [NUM_CAND];
   logic [LENGTH_BITS-1:0]   cand_len   [NUM_CAND];
   logic [LINE_BITS-1:0]     cand_line;
   logic [KIND_BITS-1:0]     head_kind;
   logic [POSITION_BITS-1:0] head_start;
   logic [LENGTH_BITS-1:0]   head_len;
   logic [LINE_BITS-1:0]     head_line;
   logic                     head_unterm;

   assign step_en = req_tvalid && req_tready;

   slex_scan #(
      .POSITION_BITS(POSITION_BITS),
      .LENGTH_BITS(LENGTH_BITS),
      .KEYWORD_CHARS(KEYWORD_CHARS)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .step_end(req_tuser[0]),
      .step_char(req_tdata),
      .cand_valid(cand_valid),
      .cand_kind(cand_kind),
      .cand_start(cand_start),
      .cand_len(cand_len),
      .cand_unterm(cand_unterm),
      .cand_line(cand_line)
   );

   slex_queue #(
      .POSITION_BITS(POSITION_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_en(step_en),
      .cand_valid(cand_valid),
      .cand_kind(cand_kind),
      .cand_start(cand_start),
      .cand_len(cand_len),
      .cand_unterm(cand_unterm),
      .cand_line(cand_line),
      .room(req_tready),
      .head_valid(rsp_tvalid),
      .head_pop(rsp_tvalid && rsp_tready),
      .head_kind(head_kind),
      .head_start(head_start),
      .head_len(head_len),
      .head_line(head_line),
      .head_unterm(head_unterm),
      .head_last(rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({head_line, head_len, head_start});
   assign rsp_tuser = {head_unterm, head_kind};

endmodule

// File: design/slex_check.sv
`timescale 1ns / 1ps
module slex_check
   import slex_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int RSP_DATA_W    = 80
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [6:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:0] == K_END |->
         rsp_tlast && rsp_tdata[POSITION_BITS +: LENGTH_BITS] == '0)
      else $error("end token not last or has length");

   a_unterm_str: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[6] |-> rsp_tuser[5:0] == K_STR && !rsp_tlast)
      else $error("unterminated flag on wrong token");

endmodule

bind source_lexer_core slex_check #(
   .POSITION_BITS(POSITION_BITS),
   .LENGTH_BITS(LENGTH_BITS),
   .RSP_DATA_W(RSP_DATA_W)
) u_slex_check (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

// File: dv/source_lexer_core_tb.sv
`timescale 1ns / 1ps
module source_lexer_core_tb;
   import slex_pkg::*;

   localparam int DATA_W = 80;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [31:0]          start;
      logic [15:0]          length;
      logic [31:0]          line;
      logic                 unterm;
      logic                 last;
   } token_type;

   // token stream predictor plus the queue of tokens still owed by the block
   class token_scoreboard;
      token_type owed[$];
      int     errors;
      scan_mode_type mode;
      logic [7:0]  op_char;
      logic [31:0] pos;
      logic [31:0] lex_start;
      logic [31:0] line;
      logic [47:0] kw_buf;
      logic [15:0] lex_len;
      token_type   batch[$];

      function void clear_scan();
         mode = MODE_IDLE;
         op_char = 0;
         pos = 0;
         lex_start = 0;
         line = 1;
         kw_buf = 0;
         lex_len = 0;
      endfunction

      function void push(logic [KIND_BITS-1:0] k, logic [31:0] s, logic [15:0] l,
                         logic u);
         token_type t;
         t = '{k, s, l, line, u, 1'b0};
         batch.push_back(t);
      endfunction

      function void grow(int n);
         if (32'hFFFF - lex_len < n) lex_len = 16'hFFFF;
         else lex_len = lex_len + 16'(n);
      endfunction

      function logic digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function logic [KIND_BITS-1:0] word_kind();
         string kw[9];
         logic [47:0] packed_kw;
         kw = '{"var", "val", "fn", "_", "type", "return", "match", "true", "false"};
         if (lex_len > 6) return K_IDENT;
         for (int k = 0; k < 9; k++) begin
            packed_kw = 0;
            for (int i = 0; i < kw[k].len(); i++) packed_kw[8*i +: 8] = kw[k][i];
            if (kw[k].len() == lex_len && packed_kw == kw_buf)
               return K_KW_BASE + KIND_BITS'(k);
         end
         return K_IDENT;
      endfunction

      function int pair_kind(logic [7:0] a, logic [7:0] b);
         if (a == ":" && b == ":") return K_COLON_COLON;
         if (a == "-" && b == ">") return K_THIN_ARROW;
         if (a == "&" && b == "&") return K_AND;
         if (a == "!" && b == "=") return K_NEQ;
         if (a == "=" && b == "=") return K_EQ_EQ;
         if (a == "=" && b == ">") return K_ARROW;
         if (a == "<" && b == "=") return K_LTE;
         if (a == ">" && b == "=") return K_GTE;
         if (a == "|" && b == "|") return K_OR;
         return -1;
      endfunction

      function int one_op_kind(logic [7:0] a);
         case (a)
            ":": return K_COLON;
            "-": return K_MINUS;
            "!": return K_NOT;
            "=": return K_EQ;
            "<": return K_LT;
            ">": return K_GT;
            "|": return K_PIPE;
            default: return -1;
         endcase
      endfunction

      function int punct_kind(logic [7:0] c);
         case (c)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            ",": return K_COMMA;
            ".": return K_DOT;
            "+": return K_PLUS;
            "/": return K_SLASH;
            "*": return K_STAR;
            default: return -1;
         endcase
      endfunction

      function void start_lexeme(scan_mode_type m);
         mode = m;
         lex_start = pos;
         lex_len = 1;
      endfunction

      // returns 1 when the byte was consumed by the pending lexeme
      function logic continue_lexeme(logic [7:0] c);
         int k;
         case (mode)
            MODE_OP: begin
               mode = MODE_IDLE;
               k = pair_kind(op_char, c);
               if (k >= 0) begin
                  push(k, lex_start, 2, 0);
                  return 1;
               end
               k = one_op_kind(op_char);
               if (k >= 0) push(k, lex_start, 1, 0);
               return 0;
            end
            MODE_INT: begin
               if (digit(c)) begin
                  grow(1);
                  return 1;
               end
               if (c == ".") begin
                  mode = MODE_DOT;
                  return 1;
               end
               push(K_NUM, lex_start, lex_len, 0);
               mode = MODE_IDLE;
               return 0;
            end
            MODE_DOT: begin
               if (digit(c)) begin
                  grow(2);
                  mode = MODE_FRAC;
                  return 1;
               end
               push(K_NUM, lex_start, lex_len, 0);
               push(K_DOT, pos - 1, 1, 0);
               mode = MODE_IDLE;
               return 0;
            end
            MODE_FRAC: begin
               if (digit(c)) begin
                  grow(1);
                  return 1;
               end
               push(K_NUM, lex_start, lex_len, 0);
               mode = MODE_IDLE;
               return 0;
            end
            MODE_IDENT: begin
               if (c == "_" || alpha(c) || digit(c)) begin
                  if (lex_len < 6) kw_buf[8*lex_len +: 8] = c;
                  grow(1);
                  return 1;
               end
               push(word_kind(), lex_start, lex_len, 0);
               mode = MODE_IDLE;
               return 0;
            end
            MODE_STR: begin
               grow(1);
               if (c == "\"") begin
                  push(K_STR, lex_start, lex_len, 0);
                  mode = MODE_IDLE;
               end else if (c == 8'h0a) begin
                  line = line + 1;
               end
               return 1;
            end
            default: begin
               mode = MODE_IDLE;
               return 0;
            end
         endcase
      endfunction

      function void scan_fresh(logic [7:0] c);
         int k;
         k = punct_kind(c);
         if (k >= 0) push(k, pos, 1, 0);
         else if (c == ":" || c == "-" || c == "&" || c == "!" || c == "=" ||
                  c == "<" || c == ">" || c == "|") begin
            start_lexeme(MODE_OP);
            op_char = c;
         end else if (c == 8'h0a) line = line + 1;
         else if (c == "\"") start_lexeme(MODE_STR);
         else if (digit(c)) start_lexeme(MODE_INT);
         else if (c == "_" || alpha(c)) begin
            start_lexeme(MODE_IDENT);
            kw_buf = 48'(c);
         end
      endfunction

      function void note_input(logic is_end, logic [7:0] c);
         int k;
         batch.delete();
         if (is_end) begin
            case (mode)
               MODE_OP: begin
                  k = one_op_kind(op_char);
                  if (k >= 0) push(k, lex_start, 1, 0);
               end
               MODE_INT, MODE_FRAC: push(K_NUM, lex_start, lex_len, 0);
               MODE_DOT: begin
                  push(K_NUM, lex_start, lex_len, 0);
                  push(K_DOT, pos - 1, 1, 0);
               end
               MODE_IDENT: push(word_kind(), lex_start, lex_len, 0);
               MODE_STR: push(K_STR, lex_start, lex_len, 1);
               default: ;
            endcase
            push(K_END, pos, 0, 0);
            clear_scan();
         end else begin
            if (!continue_lexeme(c)) scan_fresh(c);
            pos = pos + 1;
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) owed.push_back(batch[i]);
      endfunction

      function void check_token(token_type got);
         token_type exp;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected token %p", got);
            return;
         end
         exp = owed.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("token mismatch: expected %p actual %p", exp, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = 0;
   logic [0:0] req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [6:0] rsp_tuser;
   logic rsp_tlast;

   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   int cycles = 0;
   int drained = 0;
   token_scoreboard lexer_sb;

   source_lexer_core i_dut (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            lexer_sb.check_token('{rsp_tuser[5:0], rsp_tdata[31:0], rsp_tdata[47:32],
                                   rsp_tdata[79:48], rsp_tuser[6], rsp_tlast});
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   task automatic send_byte(logic is_end, logic [7:0] c);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= is_end;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lexer_sb.note_input(is_end, c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(0, s[i]);
   endtask

   task automatic send_random_source(int n);
      string pool[] = '{"var ", "val", "fn(", "_ ", "type", "return", "match", "true",
                        "false", "falsey", "x1_", "12.5", "3.", "7..8", "\"ab\nc\"",
                        "::", "->", "&&", "& ", "!=", "==", "=>", "<=", ">=", "||",
                        "|", "<", ">", "!", "=", "-", ":", " ", "\n", "{}[],+/*"};
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) send_text(pool[$urandom_range(pool.size()-1)]);
         else send_byte(0, 8'($urandom));
      end
      send_byte(1, 8'($urandom));
   endtask

   initial begin
      lexer_sb = new();
      lexer_sb.clear_scan();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: operators, keywords, number forms, lone ampersand, strings
      send_text("(a&b 1.x 2.5.\"s\n");
      send_byte(1, 8'hff);
      send_text("{val:=>7.}\x80");
      send_byte(1, 0);
      send_byte(0, 8'h00);
      send_byte(0, 8'h7f);
      send_byte(1, 0);
      for (int ph = 0; ph < 4; ph++) begin
         src_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 32 : 73) : 0;
         sink_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 32 : 73) : 0;
         for (int r = 0; r < 5; r++) send_random_source($urandom_range(3, 10));
      end
      // longer string left open at the end marker
      src_idle_pct = 0;
      sink_stall_pct = 0;
      send_byte(0, "\"");
      repeat (20) send_byte(0, "q");
      send_byte(1, 0);
      req_tvalid <= 0;
      while (lexer_sb.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (lexer_sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// File: filelist.f
design/slex_pkg.sv
design/slex_scan.sv
design/slex_queue.sv
design/source_lexer_core.sv
design/slex_check.sv
dv/source_lexer_core_tb.sv
